### sv/scbp_pkg.sv
// Shared constants, types and helpers for the sample-consensus background pixel unit.
// No dependencies.
package scbp_pkg;

    localparam int MODEL_SIZE = 16;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH  = 256;

    localparam int SLOT_W = $clog2(MODEL_SIZE);
    localparam int IDX_W  = $clog2(MODEL_SIZE + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = SLOT_W + ROW_W + COL_W;
    localparam int DEPTH  = MODEL_SIZE * MAX_HEIGHT * MAX_WIDTH;
    localparam int PIX_W  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCHES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 3'd7;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [7:0]  rem;
    } t_div_rsp;

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] n;
        n = {1'b0, s[31:1]};
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

### sv/scbp_if.sv
// Valid/ready channel interfaces for pixel requests and classification results.
// Depends on nothing.
interface scbp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       blink;
    logic [3:0] sample_index;

    modport source (output valid, req_type, row, col, red, green, blue, blink, sample_index,
                    input ready);
    modport sink   (input valid, req_type, row, col, red, green, blue, blink, sample_index,
                    output ready);
endinterface

interface scbp_out_if;
    logic       valid;
    logic       ready;
    logic       is_foreground;
    logic [4:0] match_count;

    modport source (output valid, is_foreground, match_count, input ready);
    modport sink   (input valid, is_foreground, match_count, output ready);
endinterface

### sv/sample_consensus_background_pixel_unit.sv
// Sample-consensus background pixel unit: classifies a pixel against its stored samples
// and randomly refreshes its own and a neighbour's model. Uses scbp_pkg, scbp_if,
// scbp_ram and scbp_div.
// Sequence: a load writes its slot; a classify scans the samples until enough match or all
// are scanned; a foreground result then goes out, while a background one first draws an own
// and a neighbour refresh (up to 4 divider passes; slot draws are a 4-bit mask).
// One item at a time: the next beat is taken once the sequencer is idle.
// Reset (synchronous, active low) restores register defaults and loads the LFSR with the
// default seed; the sample memory is not cleared and must be loaded before it is read.
module sample_consensus_background_pixel_unit
    import scbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    scbp_in_if.sink               i_pix,
    scbp_out_if.source            o_res
);
    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_SQ     = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_DEC    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_OWN_CH = 4'd7;
    localparam logic [3:0] S_OWN_WR = 4'd8;
    localparam logic [3:0] S_NB_CH  = 4'd9;
    localparam logic [3:0] S_NB_K   = 4'd10;
    localparam logic [3:0] S_NB_RC  = 4'd11;
    localparam logic [3:0] S_NB_WR  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    // configuration registers
    logic [8:0]  r_radius;
    logic [4:0]  r_min;
    logic [7:0]  r_per;
    logic [7:0]  r_bper;
    logic [2:0]  r_patch;
    logic [8:0]  r_fh;
    logic [8:0]  r_fw;
    logic [31:0] r_lfsr;

    // item and scan state
    logic [3:0]        r_state;
    logic [3:0]        r_ret;
    logic              r_req;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [PIX_W-1:0]  r_pix;
    logic              r_blink;
    logic [3:0]        r_slot;
    logic [IDX_W-1:0]  r_idx;
    logic [4:0]        r_cnt;
    logic              r_fg;
    logic [17:0]       r_thr;
    logic [15:0]       r_sq_r, r_sq_g, r_sq_b;
    logic [ROW_W-1:0]  r_nr;
    logic [COL_W-1:0]  r_nc;
    logic [SLOT_W-1:0] r_wslot;
    t_div_req          r_dreq;
    t_div_rsp          div_rsp;

    logic              r_ov;
    logic              r_o_fg;
    logic [4:0]        r_o_cnt;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    // derived values
    logic [7:0]  per_sel;
    logic [2:0]  patch_c;
    logic [1:0]  half;
    logic [2:0]  side;
    logic [5:0]  centre;
    logic [5:0]  n_cells;
    logic [5:0]  k_adj;
    logic [8:0]  fh_c, fw_c;
    logic signed [10:0] nr_raw, nc_raw;
    logic [7:0]  ad_r, ad_g, ad_b;
    logic [17:0] dsq;
    logic        out_free;
    logic        in_fire;
    logic [31:0] lfsr_nx;

    assign per_sel = r_blink ? ((r_bper == 8'd0) ? 8'd1 : r_bper)
                             : ((r_per  == 8'd0) ? 8'd1 : r_per);
    assign patch_c = (r_patch < 3'd3) ? 3'd3 : r_patch;
    assign half    = patch_c[2:1];
    assign side    = {half, 1'b1};
    assign centre  = 6'(half) * 6'(side) + 6'(half);
    assign n_cells = 6'(side) * 6'(side) - 6'd1;
    assign k_adj   = (div_rsp.rem[5:0] >= centre) ? div_rsp.rem[5:0] + 6'd1 : div_rsp.rem[5:0];

    assign fh_c = (r_fh == 9'd0) ? 9'd1 : ((r_fh > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : r_fh);
    assign fw_c = (r_fw == 9'd0) ? 9'd1 : ((r_fw > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : r_fw);

    // neighbour offset: quotient is the patch row, remainder the patch column
    assign nr_raw = $signed(11'(r_row)) + $signed(11'(div_rsp.quo[2:0])) - $signed(11'(half));
    assign nc_raw = $signed(11'(r_col)) + $signed(11'(div_rsp.rem[2:0])) - $signed(11'(half));

    // absolute channel differences
    assign ad_r = (r_pix[7:0]   >= ram_rdata[7:0])   ? r_pix[7:0]   - ram_rdata[7:0]
                                                     : ram_rdata[7:0]   - r_pix[7:0];
    assign ad_g = (r_pix[15:8]  >= ram_rdata[15:8])  ? r_pix[15:8]  - ram_rdata[15:8]
                                                     : ram_rdata[15:8]  - r_pix[15:8];
    assign ad_b = (r_pix[23:16] >= ram_rdata[23:16]) ? r_pix[23:16] - ram_rdata[23:16]
                                                     : ram_rdata[23:16] - r_pix[23:16];
    assign dsq = 18'(r_sq_r) + 18'(r_sq_g) + 18'(r_sq_b);

    assign out_free    = !r_ov || o_res.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign lfsr_nx     = lfsr_step(r_lfsr);

    assign o_res.valid         = r_ov;
    assign o_res.is_foreground = r_o_fg;
    assign o_res.match_count   = r_o_cnt;

    // memory port: loads and both update writes share the single write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_slot[SLOT_W-1:0], r_row, r_col};
        ram_raddr = {r_idx[SLOT_W-1:0], r_row, r_col};
        ram_wdata = r_pix;
        case (r_state)
            S_LOAD:   ram_we = (32'(r_slot) < MODEL_SIZE);
            S_OWN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_wslot, r_row, r_col};
            end
            S_NB_WR:  begin
                ram_we    = 1'b1;
                ram_waddr = {r_wslot, r_nr, r_nc};
            end
            default:  ram_we = 1'b0;
        endcase
    end

    scbp_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    scbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_thr  <= 18'(r_radius) * 18'(r_radius);
        r_sq_r <= ad_r * ad_r;
        r_sq_g <= ad_g * ad_g;
        r_sq_b <= ad_b * ad_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 9'd20;
            r_min    <= 5'd2;
            r_per    <= 8'd16;
            r_bper   <= 8'd6;
            r_patch  <= 3'd5;
            r_fh     <= 9'd256;
            r_fw     <= 9'd256;
            r_lfsr   <= 32'd1;
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ov     <= 1'b0;
            r_dreq   <= '0;
        end else begin
            r_dreq.start <= 1'b0;
            if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:      r_radius <= i_cfg_data[8:0];
                    CFG_MIN_MATCHES: r_min    <= i_cfg_data[4:0];
                    CFG_PERIOD:      r_per    <= i_cfg_data[7:0];
                    CFG_BLINK_PER:   r_bper   <= i_cfg_data[7:0];
                    CFG_PATCH:       r_patch  <= i_cfg_data[2:0];
                    CFG_HEIGHT:      r_fh     <= i_cfg_data[8:0];
                    CFG_WIDTH:       r_fw     <= i_cfg_data[8:0];
                    CFG_SEED:        r_lfsr   <= i_cfg_data;
                    default:         r_radius <= r_radius;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req   <= i_pix.req_type;
                        r_row   <= i_pix.row;
                        r_col   <= i_pix.col;
                        r_pix   <= {i_pix.blue, i_pix.green, i_pix.red};
                        r_blink <= i_pix.blink;
                        r_slot  <= i_pix.sample_index;
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_fg    <= 1'b0;
                        r_state <= i_pix.req_type ? S_LOAD : S_RD;
                    end
                end
                S_LOAD: r_state <= S_OUT;
                // scan loop: address, squares, sum and compare
                S_RD: begin
                    if (r_cnt < r_min && 32'(r_idx) < MODEL_SIZE) begin
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_SQ:  r_state <= S_SUM;
                S_SUM: begin
                    if (dsq < r_thr) begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                    r_idx   <= r_idx + IDX_W'(1);
                    r_state <= S_RD;
                end
                S_DEC: begin
                    if (r_cnt < r_min) begin
                        r_fg    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_lfsr  <= lfsr_nx;
                        r_dreq  <= '{start: 1'b1, dividend: lfsr_nx, divisor: per_sel};
                        r_ret   <= S_OWN_CH;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= r_ret;
                    end
                end
                S_OWN_CH: begin
                    r_lfsr <= lfsr_nx;
                    if (div_rsp.rem == 8'd0) begin
                        // slot draw modulo the model size: low bits of the new state
                        r_wslot <= lfsr_nx[SLOT_W-1:0];
                        r_state <= S_OWN_WR;
                    end else begin
                        r_dreq  <= '{start: 1'b1, dividend: lfsr_nx, divisor: per_sel};
                        r_ret   <= S_NB_CH;
                        r_state <= S_DIV;
                    end
                end
                S_OWN_WR: begin
                    r_lfsr  <= lfsr_nx;
                    r_dreq  <= '{start: 1'b1, dividend: lfsr_nx, divisor: per_sel};
                    r_ret   <= S_NB_CH;
                    r_state <= S_DIV;
                end
                S_NB_CH: begin
                    if (div_rsp.rem == 8'd0) begin
                        r_lfsr  <= lfsr_nx;
                        r_dreq  <= '{start: 1'b1, dividend: lfsr_nx, divisor: 8'(n_cells)};
                        r_ret   <= S_NB_K;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // split the cell number into patch row and column, centre skipped
                S_NB_K: begin
                    r_dreq  <= '{start: 1'b1, dividend: 32'(k_adj), divisor: 8'(side)};
                    r_ret   <= S_NB_RC;
                    r_state <= S_DIV;
                end
                S_NB_RC: begin
                    if (nr_raw < 0) begin
                        r_nr <= '0;
                    end else if (nr_raw >= $signed(11'(fh_c))) begin
                        r_nr <= ROW_W'(fh_c - 9'd1);
                    end else begin
                        r_nr <= ROW_W'(nr_raw);
                    end
                    if (nc_raw < 0) begin
                        r_nc <= '0;
                    end else if (nc_raw >= $signed(11'(fw_c))) begin
                        r_nc <= COL_W'(fw_c - 9'd1);
                    end else begin
                        r_nc <= COL_W'(nc_raw);
                    end
                    r_lfsr  <= lfsr_nx;
                    r_wslot <= lfsr_nx[SLOT_W-1:0];
                    r_state <= S_NB_WR;
                end
                S_NB_WR: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_o_fg  <= r_req ? 1'b0 : r_fg;
                        r_o_cnt <= r_req ? 5'd0 : r_cnt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### sv/scbp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/scbp_div.sv
// Iterative restoring divider, 32-bit dividend by 8-bit divisor, one bit a cycle.
// Depends on scbp_pkg.
module scbp_div
    import scbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [7:0]  r_rem;
    logic [7:0]  r_dvs;
    logic [8:0]  trial;
    logic        fits;

    assign trial = {r_rem, r_quo[31]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? 8'(trial - {1'b0, r_dvs}) : trial[7:0];
                r_quo <= {r_quo[30:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

### sv/scbp_chk.sv
// Port-level checker for the sample-consensus background pixel unit, bound to the top.
// Depends on the top level's ports only.
module scbp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_fg,
    input logic [4:0] i_out_cnt
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_fg) && $stable(i_out_cnt))
        else $error("result beat changed while stalled");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_cnt <= 5'd16)
        else $error("match count beyond model size");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in work");
endmodule

bind sample_consensus_background_pixel_unit scbp_chk u_scbp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_fg    (o_res.is_foreground),
    .i_out_cnt   (o_res.match_count)
);

### tb/tb.sv
// Self-checking testbench for sample_consensus_background_pixel_unit.
// Uses scbp_pkg and scbp_if; the unit's pixel model is mirrored here and checked beat by beat.
`timescale 1ns / 1ps

module tb;
    import scbp_pkg::*;

    // directed row: operation plus an optional typed-in expectation
    typedef struct {
        logic       kind;
        logic [7:0] row, col, red, green, blue;
        logic       blink;
        logic [3:0] slot;
        bit         known;
        logic       fg;
        logic [4:0] cnt;
    } t_row;

    typedef struct {
        logic       fg;
        logic [4:0] cnt;
    } t_res;

    localparam logic REQ_CLASSIFY = 1'b0;
    localparam logic REQ_LOAD     = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_RADIUS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    scbp_in_if  pix_ch ();
    scbp_out_if res_ch ();

    sample_consensus_background_pixel_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_ch.sink),
        .o_res     (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirrored state: samples live in an associative array so only written cells exist
    logic [23:0] samples [int];
    logic [31:0] rng;
    logic [8:0]  m_radius, m_height, m_width;
    logic [4:0]  m_min;
    logic [7:0]  m_period, m_blink_per;
    logic [2:0]  m_patch;

    t_res exp_q [$];
    t_res known_q [$];   // typed-in expectations, matched alongside exp_q
    bit   known_flag [$];
    int   failures = 0;
    int   n_class = 0, n_load = 0, n_fg = 0, n_updates = 0;
    bit   rx_hold = 1'b0;
    bit   stim_done = 1'b0;

    function automatic int addr(int slot, int r, int c);
        return (slot * MAX_HEIGHT + r) * MAX_WIDTH + c;
    endfunction

    // Galois step, then the new state modulo n
    function automatic int unsigned roll(int unsigned n);
        rng = rng[0] ? ({1'b0, rng[31:1]} ^ 32'h8020_0003) : {1'b0, rng[31:1]};
        return (n == 0) ? 0 : rng % n;
    endfunction

    function automatic void cfg_mirror(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            CFG_RADIUS:      m_radius    = v[8:0];
            CFG_MIN_MATCHES: m_min       = v[4:0];
            CFG_PERIOD:      m_period    = v[7:0];
            CFG_BLINK_PER:   m_blink_per = v[7:0];
            CFG_PATCH:       m_patch     = v[2:0];
            CFG_HEIGHT:      m_height    = v[8:0];
            CFG_WIDTH:       m_width     = v[8:0];
            CFG_SEED:        rng         = v;
            default: ;
        endcase
    endfunction

    // classification and random model refresh for one accepted beat
    function automatic t_res classify_pixel(t_row t);
        t_res o;
        int unsigned cnt, idx, thr, d, per, p, h, side, centre, k, fh, fw, sl;
        int nr, nc, dr, dg, db;
        logic [23:0] s, px;
        px = {t.blue, t.green, t.red};
        o.fg = 1'b0;
        o.cnt = '0;
        if (t.kind == REQ_LOAD) begin
            samples[addr(t.slot, t.row, t.col)] = px;
            return o;
        end
        cnt = 0;
        idx = 0;
        thr = m_radius * m_radius;
        while (cnt < m_min && idx < MODEL_SIZE) begin
            s = samples.exists(addr(idx, t.row, t.col)) ? samples[addr(idx, t.row, t.col)] : '0;
            dr = int'(t.red) - int'(s[7:0]);
            dg = int'(t.green) - int'(s[15:8]);
            db = int'(t.blue) - int'(s[23:16]);
            d = dr * dr + dg * dg + db * db;
            if (d < thr) cnt++;
            idx++;
        end
        o.cnt = cnt[4:0];
        if (cnt < m_min) begin
            o.fg = 1'b1;
            return o;
        end
        per = t.blink ? m_blink_per : m_period;
        if (per == 0) per = 1;
        if (roll(per) == 0) begin
            sl = roll(MODEL_SIZE);
            samples[addr(sl, t.row, t.col)] = px;
        end
        if (roll(per) == 0) begin
            p = (m_patch < 3) ? 3 : m_patch;
            h = p / 2;
            side = 2 * h + 1;
            centre = h * side + h;
            k = roll(side * side - 1);
            if (k >= centre) k++;
            fh = (m_height == 0) ? 1 : (m_height > MAX_HEIGHT) ? MAX_HEIGHT : m_height;
            fw = (m_width == 0) ? 1 : (m_width > MAX_WIDTH) ? MAX_WIDTH : m_width;
            nr = int'(t.row) + int'(k / side) - int'(h);
            nc = int'(t.col) + int'(k % side) - int'(h);
            if (nr < 0) nr = 0;
            else if (nr >= int'(fh)) nr = fh - 1;
            if (nc < 0) nc = 0;
            else if (nc >= int'(fw)) nc = fw - 1;
            sl = roll(MODEL_SIZE);
            samples[addr(sl, nr, nc)] = px;
            n_updates++;
        end
        return o;
    endfunction

    // a classify only reads its own cell, so it is safe once every slot there is written
    function automatic bit cell_ready(logic [7:0] r, logic [7:0] c);
        int i;
        for (i = 0; i < MODEL_SIZE; i++)
            if (!samples.exists(addr(i, r, c))) return 1'b0;
        return 1'b1;
    endfunction

    int burst_left = 0;

    // present one beat at the falling edge and hold it until accepted; bursts and gaps
    task automatic send_beat(t_row t, bit paced);
        int gap, i;
        if (paced && burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            for (i = 0; i < gap; i++) @(negedge i_clk) pix_ch.valid <= 1'b0;
            burst_left = $urandom_range(1, 10);
        end
        if (paced) burst_left--;
        @(negedge i_clk);
        pix_ch.valid <= 1'b1;
        pix_ch.req_type <= t.kind;
        pix_ch.row <= t.row;
        pix_ch.col <= t.col;
        pix_ch.red <= t.red;
        pix_ch.green <= t.green;
        pix_ch.blue <= t.blue;
        pix_ch.blink <= t.blink;
        pix_ch.sample_index <= t.slot;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        // beat taken at this edge: predict in acceptance order
        exp_q.push_back(classify_pixel(t));
        known_q.push_back('{fg: t.fg, cnt: t.cnt});
        known_flag.push_back(t.known);
        if (t.kind == REQ_LOAD) n_load++;
        else n_class++;
        @(negedge i_clk) pix_ch.valid <= 1'b0;
    endtask

    // wait out every outstanding result, then the block's tail latency
    task automatic drain();
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_mirror(idx, v);
    endtask

    function automatic t_row mk(logic kind, int r, int c, logic [23:0] rgb, logic bl,
                                int slot);
        t_row t;
        t.kind = kind;
        t.row = r[7:0];
        t.col = c[7:0];
        t.red = rgb[7:0];
        t.green = rgb[15:8];
        t.blue = rgb[23:16];
        t.blink = bl;
        t.slot = slot[3:0];
        t.known = 1'b0;
        t.fg = 1'b0;
        t.cnt = '0;
        return t;
    endfunction

    // fill every slot of a cell with colours near a base, so matches are plausible
    task automatic load_cell(int r, int c, logic [23:0] base, int spread);
        int i;
        logic [23:0] v;
        for (i = 0; i < MODEL_SIZE; i++) begin
            v[7:0]   = base[7:0]   + 8'($urandom_range(0, spread));
            v[15:8]  = base[15:8]  + 8'($urandom_range(0, spread));
            v[23:16] = base[23:16] + 8'($urandom_range(0, spread));
            send_beat(mk(REQ_LOAD, r, c, v, 1'($urandom_range(0, 1)), i), 1'b1);
        end
    endtask

    t_row dir_tab [$];

    initial begin
        t_row t;
        int i, n, r, c, phase, k;
        logic [23:0] base;
        pix_ch.valid = 1'b0;
        pix_ch.req_type = REQ_LOAD;
        pix_ch.row = '0;
        pix_ch.col = '0;
        pix_ch.red = '0;
        pix_ch.green = '0;
        pix_ch.blue = '0;
        pix_ch.blink = 1'b0;
        pix_ch.sample_index = '0;
        cfg_mirror(CFG_RADIUS, 20);
        cfg_mirror(CFG_MIN_MATCHES, 2);
        cfg_mirror(CFG_PERIOD, 16);
        cfg_mirror(CFG_BLINK_PER, 6);
        cfg_mirror(CFG_PATCH, 5);
        cfg_mirror(CFG_HEIGHT, 256);
        cfg_mirror(CFG_WIDTH, 256);
        cfg_mirror(CFG_SEED, 1);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // ---- directed part, reset settings ----
        // corner cells at the extremes of row and column, all slots loaded
        for (i = 0; i < MODEL_SIZE; i++)
            dir_tab.push_back(mk(REQ_LOAD, 0, 0, 24'h000000, 1'b0, i));
        for (i = 0; i < MODEL_SIZE; i++)
            dir_tab.push_back(mk(REQ_LOAD, 255, 255, 24'hFFFFFF, 1'b1, i));
        // load results are fixed at zero
        foreach (dir_tab[j]) dir_tab[j].known = 1'b1;
        // exact match on black: two matches, background
        t = mk(REQ_CLASSIFY, 0, 0, 24'h000000, 1'b0, 0);
        t.known = 1'b1; t.fg = 1'b0; t.cnt = 5'd2;
        dir_tab.push_back(t);
        // white against black samples: no match anywhere, foreground with zero count
        t = mk(REQ_CLASSIFY, 0, 0, 24'hFFFFFF, 1'b1, 0);
        t.known = 1'b1; t.fg = 1'b1; t.cnt = 5'd0;
        dir_tab.push_back(t);
        // white on the far corner with blink set
        dir_tab.push_back(mk(REQ_CLASSIFY, 255, 255, 24'hFFFFFF, 1'b1, 15));
        // slot out of range is impossible at 4 bits; top slot rewrite instead
        dir_tab.push_back(mk(REQ_LOAD, 255, 255, 24'hFEFEFE, 1'b0, 15));
        dir_tab.push_back(mk(REQ_CLASSIFY, 255, 255, 24'hF0F0F0, 1'b0, 0));
        foreach (dir_tab[j]) send_beat(dir_tab[j], 1'b0);
        drain();

        // ---- random phases: each sets all registers, extremes among them ----
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin cfg_write(CFG_RADIUS, 0);   cfg_write(CFG_MIN_MATCHES, 1);
                         cfg_write(CFG_PERIOD, 1);   cfg_write(CFG_BLINK_PER, 1);
                         cfg_write(CFG_PATCH, 3);    cfg_write(CFG_HEIGHT, 1);
                         cfg_write(CFG_WIDTH, 1);    cfg_write(CFG_SEED, 32'hFFFF_FFFF); end
                1: begin cfg_write(CFG_RADIUS, 442); cfg_write(CFG_MIN_MATCHES, 16);
                         cfg_write(CFG_PERIOD, 255); cfg_write(CFG_BLINK_PER, 255);
                         cfg_write(CFG_PATCH, 7);    cfg_write(CFG_HEIGHT, 256);
                         cfg_write(CFG_WIDTH, 256);  cfg_write(CFG_SEED, 32'hACE1_2345); end
                2: begin cfg_write(CFG_RADIUS, 30);  cfg_write(CFG_MIN_MATCHES, 0);
                         cfg_write(CFG_PERIOD, 0);   cfg_write(CFG_BLINK_PER, 2);
                         cfg_write(CFG_PATCH, 0);    cfg_write(CFG_HEIGHT, 0);
                         cfg_write(CFG_WIDTH, 511);  cfg_write(CFG_SEED, 0); end
                default: begin
                    cfg_write(CFG_RADIUS, $urandom_range(5, 60));
                    cfg_write(CFG_MIN_MATCHES, $urandom_range(1, 6));
                    cfg_write(CFG_PERIOD, $urandom_range(1, 4));
                    cfg_write(CFG_BLINK_PER, $urandom_range(1, 4));
                    cfg_write(CFG_PATCH, $urandom_range(3, 7));
                    cfg_write(CFG_HEIGHT, $urandom_range(1, 256));
                    cfg_write(CFG_WIDTH, $urandom_range(1, 256));
                    cfg_write(CFG_SEED, $urandom());
                end
            endcase
            n = 0;
            while (n < 60) begin
                // mostly pixels near a few loaded cells, so refreshes and matches happen
                r = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 5);
                c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 5);
                base = {8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
                        8'($urandom_range(0, 200))};
                if (!cell_ready(r, c)) begin
                    load_cell(r, c, base, 20);
                    n += MODEL_SIZE;
                end
                for (k = 0; k < 4; k++) begin
                    t = mk(REQ_CLASSIFY, r, c, base + 24'($urandom_range(0, 24'h0F0F0F)),
                           1'($urandom_range(0, 1)), 0);
                    if ($urandom_range(0, 4) == 0) t = mk(REQ_LOAD, r, c, 24'($urandom()),
                                                          1'($urandom_range(0, 1)),
                                                          $urandom_range(0, 15));
                    if ($urandom_range(0, 9) == 0) t.red = 8'($urandom());
                    send_beat(t, 1'b1);
                    n++;
                end
            end
            drain();
        end
        stim_done = 1'b1;
    end

    // ---------------- receiver: stall pattern plus one long hold-off ----------------
    int stall_len = 0;

    always @(negedge i_clk) begin
        if (rx_hold) begin
            res_ch.ready <= 1'b0;
        end else if (stall_len > 0) begin
            res_ch.ready <= 1'b0;
            stall_len <= stall_len - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            stall_len <= $urandom_range(0, 6);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // hold results back for a long stretch so the input side must stall
    initial begin
        int cyc;
        cyc = 0;
        while (n_class < 40) @(posedge i_clk);
        rx_hold = 1'b1;
        while (cyc < 3000) begin
            @(posedge i_clk);
            cyc++;
        end
        rx_hold = 1'b0;
    end

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        t_res e, kn;
        bit kf;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (exp_q.size() == 0) begin
                $error("result beat with nothing expected: fg=%0d cnt=%0d",
                       res_ch.is_foreground, res_ch.match_count);
                failures++;
            end else begin
                e = exp_q.pop_front();
                kn = known_q.pop_front();
                kf = known_flag.pop_front();
                if (kf) e = kn;   // typed-in value overrides for the directed rows
                if (res_ch.is_foreground !== e.fg) begin
                    $error("is_foreground: expected %0d, got %0d", e.fg, res_ch.is_foreground);
                    failures++;
                end
                if (res_ch.match_count !== e.cnt) begin
                    $error("match_count: expected %0d, got %0d", e.cnt, res_ch.match_count);
                    failures++;
                end
                if (e.fg) n_fg++;
            end
        end
    end

    // ---------------- end of run ----------------
    initial begin
        wait (stim_done);
        $display("covered %0d classifications (%0d foreground), %0d sample loads,",
                 n_class, n_fg, n_load);
        $display("%0d neighbour refreshes, over several register settings and a long stall",
                 n_updates);
        if (failures == 0 && exp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule

### filelist.f
sv/scbp_pkg.sv
sv/scbp_if.sv
sv/scbp_ram.sv
sv/scbp_div.sv
sv/sample_consensus_background_pixel_unit.sv
sv/scbp_chk.sv
tb/tb.sv
